FILE: hdl/jsu_pkg.sv
// Shared types and constants for the JSON string unescape block.
// Holds the status codes and the result group passed from decoder to output queue.
// No dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int GRP_BYTES   = 4;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_CLOSED      = 4'd1,
    ST_NO_QUOTE    = 4'd2,
    ST_CONTROL     = 4'd3,
    ST_TRUNC_ESC   = 4'd4,
    ST_BAD_ESC     = 4'd5,
    ST_BAD_HEX     = 4'd6,
    ST_TRUNC_HEX   = 4'd7,
    ST_NO_LOW      = 4'd8,
    ST_BAD_LOW     = 4'd9,
    ST_STRAY_LOW   = 4'd10,
    ST_BAD_LEAD    = 4'd11,
    ST_TRUNC_UTF8  = 4'd12,
    ST_BAD_CONT    = 4'd13,
    ST_OVERLONG    = 4'd14,
    ST_UNTERMINATED = 4'd15
  } status_e;

  // All results caused by one source byte: up to four data bytes or one status.
  typedef struct packed {
    logic [2:0]                     count;
    logic                           is_data;
    status_e                        status;
    logic [GRP_BYTES-1:0][7:0]      data;
  } grp_t;

endpackage

FILE: hdl/jsu_decode.sv
// Decoder state machine: one source byte in, at most one result group out per step.
// Handles escapes, hex quads, surrogate pairs and raw UTF-8 checking.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       eos_i,
  output grp_t       grp_o
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX1,
    PH_SBS,
    PH_SU,
    PH_HEX2,
    PH_UTF8,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        hbad_q, hbad_d;
  logic [9:0]  hsur_q, hsur_d;
  logic [7:0]  buf_q [3];
  logic [7:0]  buf_d [3];
  logic [2:0]  exp_q, exp_d;
  logic [2:0]  rcv_q, rcv_d;
  logic        cbad_q, cbad_d;
  logic        rbad_q, rbad_d;

  logic        hex_ok;
  logic [3:0]  hex_dig;
  logic [15:0] hex_v;
  logic        hex_bad_all;
  logic        hex_last;
  logic [20:0] cp;
  grp_t        enc_grp;
  logic [2:0]  n_utf;
  logic        cb;
  logic        rb;
  grp_t        grp;

  function automatic grp_t status_grp(status_e code);
    grp_t g;
    g         = '0;
    g.count   = 3'd1;
    g.is_data = 1'b0;
    g.status  = code;
    return g;
  endfunction

  function automatic grp_t encode(logic [20:0] c);
    grp_t g;
    g         = '0;
    g.is_data = 1'b1;
    g.status  = ST_OK;
    if (c <= 21'h7f) begin
      g.count   = 3'd1;
      g.data[0] = c[7:0];
    end else if (c <= 21'h7ff) begin
      g.count   = 3'd2;
      g.data[0] = {3'b110, c[10:6]};
      g.data[1] = {2'b10, c[5:0]};
    end else if (c <= 21'hffff) begin
      g.count   = 3'd3;
      g.data[0] = {4'b1110, c[15:12]};
      g.data[1] = {2'b10, c[11:6]};
      g.data[2] = {2'b10, c[5:0]};
    end else begin
      g.count   = 3'd4;
      g.data[0] = {5'b11110, c[20:18]};
      g.data[1] = {2'b10, c[17:12]};
      g.data[2] = {2'b10, c[11:6]};
      g.data[3] = {2'b10, c[5:0]};
    end
    return g;
  endfunction

  always_comb begin
    hex_ok  = 1'b1;
    hex_dig = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_dig = byte_i[3:0];
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      hex_dig = byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_v       = {acc_q[11:0], hex_dig};
  assign hex_bad_all = hbad_q | ~hex_ok;
  assign hex_last    = (cnt_q == 2'd3);
  assign cp          = (phase_q == PH_HEX2) ? (21'h10000 + {1'b0, hsur_q, hex_v[9:0]})
                                            : {5'd0, hex_v};
  assign enc_grp     = encode(cp);
  assign n_utf       = rcv_q + 3'd1;
  assign cb          = cbad_q | (byte_i[7:6] != 2'b10);
  assign rb          = rbad_q | ((rcv_q == 3'd1) &&
                       ((buf_q[0] == 8'he0 && byte_i < 8'ha0) ||
                        (buf_q[0] == 8'hed && byte_i > 8'h9f) ||
                        (buf_q[0] == 8'hf0 && byte_i < 8'h90) ||
                        (buf_q[0] == 8'hf4 && byte_i > 8'h8f)));

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    hbad_d  = hbad_q;
    hsur_d  = hsur_q;
    buf_d   = buf_q;
    exp_d   = exp_q;
    rcv_d   = rcv_q;
    cbad_d  = cbad_q;
    rbad_d  = rbad_q;
    grp     = '0;
    case (phase_q)
      PH_IDLE: begin
        if (eos_i || byte_i != CH_QUOTE) begin
          grp     = status_grp(ST_NO_QUOTE);
          phase_d = PH_DONE;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        if (eos_i) begin
          grp     = status_grp(ST_UNTERMINATED);
          phase_d = PH_DONE;
        end else if (byte_i == CH_QUOTE) begin
          grp     = status_grp(ST_CLOSED);
          phase_d = PH_DONE;
        end else if (byte_i < 8'h20) begin
          grp     = status_grp(ST_CONTROL);
          phase_d = PH_DONE;
        end else if (byte_i == CH_BSLASH) begin
          phase_d = PH_ESC;
        end else if (byte_i < 8'h80) begin
          grp = encode({13'd0, byte_i});
        end else if (byte_i < 8'hc2 || byte_i > 8'hf4) begin
          grp     = status_grp(ST_BAD_LEAD);
          phase_d = PH_DONE;
        end else begin
          if (byte_i <= 8'hdf) begin
            exp_d = 3'd2;
          end else if (byte_i <= 8'hef) begin
            exp_d = 3'd3;
          end else begin
            exp_d = 3'd4;
          end
          buf_d[0] = byte_i;
          rcv_d    = 3'd1;
          cbad_d   = 1'b0;
          rbad_d   = 1'b0;
          phase_d  = PH_UTF8;
        end
      end
      PH_ESC: begin
        phase_d = PH_BODY;
        if (eos_i) begin
          grp     = status_grp(ST_TRUNC_ESC);
          phase_d = PH_DONE;
        end else begin
          case (byte_i)
            CH_QUOTE:  grp = encode({13'd0, CH_QUOTE});
            CH_BSLASH: grp = encode({13'd0, CH_BSLASH});
            CH_SLASH:  grp = encode({13'd0, CH_SLASH});
            CH_B:      grp = encode(21'h08);
            CH_F:      grp = encode(21'h0c);
            CH_N:      grp = encode(21'h0a);
            CH_R:      grp = encode(21'h0d);
            CH_T:      grp = encode(21'h09);
            CH_U: begin
              acc_d   = 16'd0;
              cnt_d   = 2'd0;
              hbad_d  = 1'b0;
              phase_d = PH_HEX1;
            end
            default: begin
              grp     = status_grp(ST_BAD_ESC);
              phase_d = PH_DONE;
            end
          endcase
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (eos_i) begin
          grp     = status_grp(ST_TRUNC_HEX);
          phase_d = PH_DONE;
        end else begin
          acc_d  = hex_v;
          hbad_d = hex_bad_all;
          if (!hex_last) begin
            cnt_d = cnt_q + 2'd1;
          end else if (hex_bad_all) begin
            grp     = status_grp(ST_BAD_HEX);
            phase_d = PH_DONE;
          end else if (phase_q == PH_HEX1) begin
            if (hex_v[15:10] == 6'b110110) begin
              hsur_d  = hex_v[9:0];
              phase_d = PH_SBS;
            end else if (hex_v[15:10] == 6'b110111) begin
              grp     = status_grp(ST_STRAY_LOW);
              phase_d = PH_DONE;
            end else begin
              grp     = enc_grp;
              phase_d = PH_BODY;
            end
          end else begin
            if (hex_v[15:10] != 6'b110111) begin
              grp     = status_grp(ST_BAD_LOW);
              phase_d = PH_DONE;
            end else begin
              grp     = enc_grp;
              phase_d = PH_BODY;
            end
          end
        end
      end
      PH_SBS: begin
        if (eos_i || byte_i != CH_BSLASH) begin
          grp     = status_grp(ST_NO_LOW);
          phase_d = PH_DONE;
        end else begin
          phase_d = PH_SU;
        end
      end
      PH_SU: begin
        if (eos_i || byte_i != CH_U) begin
          grp     = status_grp(ST_NO_LOW);
          phase_d = PH_DONE;
        end else begin
          acc_d   = 16'd0;
          cnt_d   = 2'd0;
          hbad_d  = 1'b0;
          phase_d = PH_HEX2;
        end
      end
      PH_UTF8: begin
        if (eos_i) begin
          grp     = status_grp(ST_TRUNC_UTF8);
          phase_d = PH_DONE;
        end else begin
          cbad_d = cb;
          rbad_d = rb;
          if (n_utf < exp_q) begin
            buf_d[rcv_q[1:0]] = byte_i;
            rcv_d             = n_utf;
          end else if (cb) begin
            grp     = status_grp(ST_BAD_CONT);
            phase_d = PH_DONE;
          end else if (rb) begin
            grp     = status_grp(ST_OVERLONG);
            phase_d = PH_DONE;
          end else begin
            grp.count   = n_utf;
            grp.is_data = 1'b1;
            grp.status  = ST_OK;
            grp.data[0] = buf_q[0];
            grp.data[1] = (n_utf == 3'd2) ? byte_i : buf_q[1];
            grp.data[2] = (n_utf == 3'd3) ? byte_i : buf_q[2];
            grp.data[3] = byte_i;
            phase_d     = PH_BODY;
          end
        end
      end
      PH_DONE: begin
        grp = '0;
      end
      default: begin
        grp = '0;
      end
    endcase
  end

  assign grp_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= 16'd0;
      cnt_q   <= 2'd0;
      hbad_q  <= 1'b0;
      hsur_q  <= 10'd0;
      exp_q   <= 3'd0;
      rcv_q   <= 3'd0;
      cbad_q  <= 1'b0;
      rbad_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      hbad_q  <= hbad_d;
      hsur_q  <= hsur_d;
      exp_q   <= exp_d;
      rcv_q   <= rcv_d;
      cbad_q  <= cbad_d;
      rbad_q  <= rbad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      buf_q <= buf_d;
    end
  end

endmodule

FILE: hdl/jsu_out_queue.sv
// Result queue: holds whole result groups and hands them out one item at a time.
// A group leaves the queue when its final item is taken.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_out_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  grp_t       push_grp_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [3:0] status_o,
  output logic       last_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic [1:0]    idx_q;
  grp_t          head;
  logic          out_fire;
  logic          pop;
  logic          do_push;

  assign head        = mem_q[rd_ptr_q];
  assign full_o      = (count_q == CW'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o & out_ready_i;
  assign last_o      = ({1'b0, idx_q} == (head.count - 3'd1));
  assign pop         = out_fire & last_o;
  assign do_push     = push_i & ~full_o;

  assign out_byte_o   = head.is_data ? head.data[idx_q] : 8'h00;
  assign byte_valid_o = head.is_data;
  assign status_o     = head.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      idx_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
        idx_q    <= 2'd0;
      end else if (out_fire) begin
        idx_q <= idx_q + 2'd1;
      end
      if (do_push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_grp_i;
    end
  end

endmodule

FILE: hdl/json_string_unescape_utf8.sv
// Top level of the JSON string unescape block with UTF-8 checking.
// Input stage register, decoder and result queue; depends on jsu_pkg,
// jsu_decode and jsu_out_queue.
//
//   Channel  Handshake                 Payload
//   in       in_valid_i / in_ready_o   in_byte_i, end_of_source_i
//   out      out_valid_o / out_ready_i out_byte_o, byte_valid_o, status_o, last_o
//
// One source byte is accepted per cycle; it is held in the input stage register
// until the queue has room, then decoded into the queue. The rate is set by the
// result queue, which holds QUEUE_DEPTH groups of up to four items and drains one
// item per cycle while out_ready_i is high; input stalls only when it is full.
// Reset clears the decoder to wait for the opening quote and empties the queue.
// After the closing quote or an error no further results appear until reset.
`timescale 1ns / 1ps

module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_source_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [3:0] status_o,
  output logic       last_o
);

  logic       s_valid_q;
  logic [7:0] s_byte_q;
  logic       s_eos_q;
  logic       q_full;
  logic       step;
  logic       in_fire;
  grp_t       grp;

  assign step       = s_valid_q & ~q_full;
  assign in_ready_o = ~s_valid_q | ~q_full;
  assign in_fire    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= in_fire | (s_valid_q & ~step);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_byte_q <= in_byte_i;
      s_eos_q  <= end_of_source_i;
    end
  end

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s_byte_q),
    .eos_i  (s_eos_q),
    .grp_o  (grp)
  );

  jsu_out_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (step && grp.count != 3'd0),
    .push_grp_i   (grp),
    .full_o       (q_full),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

FILE: hdl/jsu_checker.sv
// Port-level checker for the JSON string unescape block, with its bind.
// Depends on jsu_pkg and the top level json_string_unescape_utf8.
`timescale 1ns / 1ps

module jsu_checker
  import jsu_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       end_of_source_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic [3:0] status_o,
  input logic       last_o
);

  // A waiting source item keeps its valid and payload until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i) &&
    $stable(end_of_source_i))
    else $error("waiting source item changed");

  // A status item always closes the results of its source byte.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_o)
    else $error("status item not marked last");

  // Data items carry status ok; status items carry a zero byte and a non-zero code.
  a_item_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_valid_o ? (status_o == ST_OK)
                                  : (out_byte_o == 8'h00 && status_o != ST_OK)))
    else $error("malformed result item");

  // Once a status item has been taken, the string is finished and nothing follows.
  a_quiet_after_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !byte_valid_o |=> !out_valid_o)
    else $error("item offered after final status");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(byte_valid_o) && $stable(status_o) && $stable(last_o))
    else $error("stalled result item changed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_chk (.*);

FILE: tb/sv/json_string_unescape_utf8_tb.sv
// Self-checking testbench for the JSON string unescape block with UTF-8 checking.
// A directed table and a random stream of string tokens are checked against a built-in decoder.
// Depends on jsu_pkg and json_string_unescape_utf8.
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    DP_QUOTE, DP_BODY, DP_ESC, DP_HEX_HI, DP_PAIR_BS, DP_PAIR_U, DP_HEX_LO, DP_SEQ, DP_DONE
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    status_e    status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } src_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_want;
    logic [2:0] n;
    logic [7:0] want;
  } dir_row_t;

  localparam int MAX_SHOWN  = 10;
  localparam int RAND_ITEMS = 180;
  localparam int MAX_WAIT   = 11;
  localparam int DIR_ROWS   = 29;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       end_of_source_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic [3:0] status_o;
  logic       last_o;

  json_string_unescape_utf8 u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .end_of_source_i(end_of_source_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Decoder state
  dec_phase_e  dec_phase;
  logic [15:0] quad_acc;
  logic [1:0]  quad_cnt;
  logic        quad_bad;
  logic [9:0]  hi_bits;
  logic [7:0]  seq_buf [3];
  logic [2:0]  seq_len;
  logic [2:0]  seq_cnt;
  logic        seq_cont_bad;
  logic        seq_range_bad;

  out_item_t   step_res [4];
  int          step_n;
  out_item_t   decoded_q [$];
  src_item_t   src_q [$];

  int          items_sent;
  int          ignored_items;
  int          results_seen;
  int          data_seen;
  int          mism_cnt;
  int unsigned stall_left;
  int unsigned stall_draw;
  bit          calm;
  status_e     last_status;
  status_e     ending;

  logic [7:0]  esc_set [8] = '{8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74};

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'h22, 1'b1, 3'd0, 8'h00}, '{8'h20, 1'b1, 3'd1, 8'h20}, '{8'h7f, 1'b1, 3'd1, 8'h7f},
    '{8'h5c, 1'b1, 3'd0, 8'h00}, '{8'h6e, 1'b1, 3'd1, 8'h0a},
    '{8'h5c, 1'b1, 3'd0, 8'h00}, '{8'h75, 1'b1, 3'd0, 8'h00}, '{8'h30, 1'b1, 3'd0, 8'h00},
    '{8'h30, 1'b1, 3'd0, 8'h00}, '{8'h30, 1'b1, 3'd0, 8'h00}, '{8'h30, 1'b1, 3'd1, 8'h00},
    '{8'h5c, 1'b0, 3'd0, 8'h00}, '{8'h75, 1'b0, 3'd0, 8'h00}, '{8'h44, 1'b0, 3'd0, 8'h00},
    '{8'h42, 1'b0, 3'd0, 8'h00}, '{8'h66, 1'b0, 3'd0, 8'h00}, '{8'h46, 1'b0, 3'd0, 8'h00},
    '{8'h5c, 1'b0, 3'd0, 8'h00}, '{8'h75, 1'b0, 3'd0, 8'h00}, '{8'h64, 1'b0, 3'd0, 8'h00},
    '{8'h46, 1'b0, 3'd0, 8'h00}, '{8'h46, 1'b0, 3'd0, 8'h00}, '{8'h66, 1'b0, 3'd0, 8'h00},
    '{8'hc2, 1'b0, 3'd0, 8'h00}, '{8'h80, 1'b0, 3'd0, 8'h00},
    '{8'hf4, 1'b0, 3'd0, 8'h00}, '{8'h8f, 1'b0, 3'd0, 8'h00}, '{8'hbf, 1'b0, 3'd0, 8'h00},
    '{8'hbf, 1'b0, 3'd0, 8'h00}
  };

  task automatic expect_item(input out_item_t it);
    decoded_q = {decoded_q, it};
  endtask

  task automatic emit_status(input status_e s);
    step_res[0] = '{data: 8'h00, valid: 1'b0, status: s, last: 1'b1};
    step_n      = 1;
    dec_phase   = DP_DONE;
  endtask

  task automatic emit_bytes(input logic [3:0][7:0] b, input int n);
    for (int k = 0; k < n; k++) begin
      step_res[k] = '{data: b[k], valid: 1'b1, status: ST_OK, last: (k == n - 1)};
    end
    step_n = n;
  endtask

  task automatic emit_code_point(input logic [20:0] cp);
    logic [3:0][7:0] b;
    b = '0;
    dec_phase = DP_BODY;
    if (cp <= 21'h7f) begin
      b[0] = cp[7:0];
      emit_bytes(b, 1);
    end else if (cp <= 21'h7ff) begin
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
      emit_bytes(b, 2);
    end else if (cp <= 21'hffff) begin
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
      emit_bytes(b, 3);
    end else begin
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
      emit_bytes(b, 4);
    end
  endtask

  task automatic quad_clear(input dec_phase_e next);
    quad_acc  = '0;
    quad_cnt  = '0;
    quad_bad  = 1'b0;
    dec_phase = next;
  endtask

  // Any byte counts as a digit; a non-hex one only marks the quad as bad.
  task automatic quad_shift(input logic [7:0] c, output logic done);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) d = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) d = c[3:0] + 4'd9;
    else quad_bad = 1'b1;
    quad_acc = {quad_acc[11:0], d};
    done = (quad_cnt == 2'd3);
    if (!done) quad_cnt = quad_cnt + 2'd1;
  endtask

  task automatic decode_source_byte(input logic [7:0] c, input logic eos);
    logic            done;
    logic            ok;
    logic [7:0]      r;
    logic [3:0][7:0] b;
    int              n;
    step_n = 0;
    b      = '0;
    case (dec_phase)
      DP_QUOTE: begin
        if (eos || c != 8'h22) emit_status(ST_NO_QUOTE);
        else dec_phase = DP_BODY;
      end
      DP_BODY: begin
        if (eos) emit_status(ST_UNTERMINATED);
        else if (c == 8'h22) emit_status(ST_CLOSED);
        else if (c < 8'h20) emit_status(ST_CONTROL);
        else if (c == 8'h5c) dec_phase = DP_ESC;
        else if (c < 8'h80) begin
          b[0] = c;
          emit_bytes(b, 1);
        end else begin
          if (c >= 8'hc2 && c <= 8'hdf) seq_len = 3'd2;
          else if (c >= 8'he0 && c <= 8'hef) seq_len = 3'd3;
          else if (c >= 8'hf0 && c <= 8'hf4) seq_len = 3'd4;
          else seq_len = 3'd0;
          if (seq_len == 3'd0) begin
            emit_status(ST_BAD_LEAD);
          end else begin
            seq_buf[0]    = c;
            seq_cnt       = 3'd1;
            seq_cont_bad  = 1'b0;
            seq_range_bad = 1'b0;
            dec_phase     = DP_SEQ;
          end
        end
      end
      DP_ESC: begin
        if (eos) emit_status(ST_TRUNC_ESC);
        else if (c == 8'h75) quad_clear(DP_HEX_HI);
        else begin
          ok = 1'b1;
          r  = c;
          case (c)
            8'h22, 8'h5c, 8'h2f: r = c;
            8'h62: r = 8'h08;
            8'h66: r = 8'h0c;
            8'h6e: r = 8'h0a;
            8'h72: r = 8'h0d;
            8'h74: r = 8'h09;
            default: ok = 1'b0;
          endcase
          if (!ok) emit_status(ST_BAD_ESC);
          else begin
            dec_phase = DP_BODY;
            b[0] = r;
            emit_bytes(b, 1);
          end
        end
      end
      DP_HEX_HI: begin
        if (eos) emit_status(ST_TRUNC_HEX);
        else begin
          quad_shift(c, done);
          if (done) begin
            if (quad_bad) emit_status(ST_BAD_HEX);
            else if (quad_acc >= 16'hd800 && quad_acc <= 16'hdbff) begin
              hi_bits   = quad_acc[9:0];
              dec_phase = DP_PAIR_BS;
            end else if (quad_acc >= 16'hdc00 && quad_acc <= 16'hdfff) emit_status(ST_STRAY_LOW);
            else emit_code_point({5'd0, quad_acc});
          end
        end
      end
      DP_PAIR_BS: begin
        if (eos || c != 8'h5c) emit_status(ST_NO_LOW);
        else dec_phase = DP_PAIR_U;
      end
      DP_PAIR_U: begin
        if (eos || c != 8'h75) emit_status(ST_NO_LOW);
        else quad_clear(DP_HEX_LO);
      end
      DP_HEX_LO: begin
        if (eos) emit_status(ST_TRUNC_HEX);
        else begin
          quad_shift(c, done);
          if (done) begin
            if (quad_bad) emit_status(ST_BAD_HEX);
            else if (quad_acc < 16'hdc00 || quad_acc > 16'hdfff) emit_status(ST_BAD_LOW);
            else emit_code_point(21'h10000 + {1'b0, hi_bits, quad_acc[9:0]});
          end
        end
      end
      DP_SEQ: begin
        if (eos) emit_status(ST_TRUNC_UTF8);
        else begin
          if (c[7:6] != 2'b10) seq_cont_bad = 1'b1;
          if (seq_cnt == 3'd1) begin
            if ((seq_buf[0] == 8'he0 && c < 8'ha0) || (seq_buf[0] == 8'hed && c > 8'h9f) ||
                (seq_buf[0] == 8'hf0 && c < 8'h90) || (seq_buf[0] == 8'hf4 && c > 8'h8f))
              seq_range_bad = 1'b1;
          end
          n = int'(seq_cnt) + 1;
          if (n < int'(seq_len) && seq_cnt < 3'd3) begin
            seq_buf[seq_cnt] = c;
            seq_cnt = seq_cnt + 3'd1;
          end else if (seq_cont_bad) emit_status(ST_BAD_CONT);
          else if (seq_range_bad) emit_status(ST_OVERLONG);
          else begin
            if (n > 4) n = 4;
            for (int k = 0; k + 1 < n; k++) b[k] = seq_buf[k];
            b[n-1]    = c;
            dec_phase = DP_BODY;
            emit_bytes(b, n);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Source generation

  task automatic put_src(input logic [7:0] d, input logic e);
    src_item_t it;
    it    = '{data: d, eos: e};
    src_q = {src_q, it};
  endtask

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return ($urandom_range(0, 1) != 0) ? 8'h57 + {4'd0, n} : 8'h37 + {4'd0, n};
  endfunction

  task automatic put_quad(input logic [15:0] v);
    put_src(8'h5c, 1'b0);
    put_src(8'h75, 1'b0);
    for (int k = 3; k >= 0; k--) put_src(hex_char(v[k*4 +: 4]), 1'b0);
  endtask

  task automatic put_high(output logic [15:0] v);
    v = 16'hd800 + 16'($urandom_range(0, 1023));
    put_quad(v);
  endtask

  task automatic put_lead(output logic [7:0] lead, output int len);
    len = $urandom_range(2, 4);
    case (len)
      2:       lead = 8'($urandom_range(8'hc2, 8'hdf));
      3:       lead = 8'($urandom_range(8'he0, 8'hef));
      default: lead = 8'($urandom_range(8'hf0, 8'hf4));
    endcase
    put_src(lead, 1'b0);
  endtask

  task automatic put_token();
    logic [7:0]  c;
    logic [7:0]  lead;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] v;
    int          len;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        do c = 8'($urandom_range(8'h20, 8'h7f)); while (c == 8'h22 || c == 8'h5c);
        put_src(c, 1'b0);
      end
      4: begin
        put_src(8'h5c, 1'b0);
        put_src(esc_set[$urandom_range(0, 7)], 1'b0);
      end
      5, 6: begin
        case ($urandom_range(0, 2))
          0:       v = 16'($urandom_range(0, 16'h7f));
          1:       v = 16'($urandom_range(16'h80, 16'h7ff));
          default: do v = 16'($urandom_range(16'h800, 16'hffff)); while (v[15:11] == 5'b11011);
        endcase
        put_quad(v);
      end
      7: begin
        put_high(v);
        put_quad(16'hdc00 + 16'($urandom_range(0, 1023)));
      end
      default: begin
        put_lead(lead, len);
        lo = 8'h80;
        hi = 8'hbf;
        if (lead == 8'he0) lo = 8'ha0;
        if (lead == 8'hed) hi = 8'h9f;
        if (lead == 8'hf0) lo = 8'h90;
        if (lead == 8'hf4) hi = 8'h8f;
        put_src(8'($urandom_range(lo, hi)), 1'b0);
        for (int k = 2; k < len; k++) put_src(8'($urandom_range(8'h80, 8'hbf)), 1'b0);
      end
    endcase
  endtask

  task automatic put_ending(input status_e s);
    logic [7:0]  c;
    logic [7:0]  lead;
    logic [15:0] v;
    int          len;
    int          pos;
    case (s)
      ST_CLOSED:       put_src(8'h22, 1'b0);
      ST_CONTROL:      put_src(8'($urandom_range(0, 31)), 1'b0);
      ST_UNTERMINATED: put_src(8'($urandom), 1'b1);
      ST_TRUNC_ESC: begin
        put_src(8'h5c, 1'b0);
        put_src(8'($urandom), 1'b1);
      end
      ST_BAD_ESC: begin
        put_src(8'h5c, 1'b0);
        do c = 8'($urandom); while (c == 8'h75 || c inside {esc_set});
        put_src(c, 1'b0);
      end
      ST_BAD_HEX, ST_TRUNC_HEX: begin
        if ($urandom_range(0, 1) != 0) put_high(v);
        put_src(8'h5c, 1'b0);
        put_src(8'h75, 1'b0);
        if (s == ST_TRUNC_HEX) begin
          repeat ($urandom_range(0, 3)) put_src(8'($urandom), 1'b0);
          put_src(8'($urandom), 1'b1);
        end else begin
          pos = $urandom_range(0, 3);
          for (int k = 0; k < 4; k++) begin
            if (k == pos) begin
              do c = 8'($urandom); while (is_hex(c));
            end else begin
              c = hex_char(4'($urandom));
            end
            put_src(c, 1'b0);
          end
        end
      end
      ST_NO_LOW: begin
        put_high(v);
        case ($urandom_range(0, 3))
          0: begin
            do c = 8'($urandom); while (c == 8'h5c);
            put_src(c, 1'b0);
          end
          1: begin
            put_src(8'h5c, 1'b0);
            do c = 8'($urandom); while (c == 8'h75);
            put_src(c, 1'b0);
          end
          2: put_src(8'($urandom), 1'b1);
          default: begin
            put_src(8'h5c, 1'b0);
            put_src(8'($urandom), 1'b1);
          end
        endcase
      end
      ST_BAD_LOW: begin
        put_high(v);
        do v = 16'($urandom); while (v[15:10] == 6'b110111);
        put_quad(v);
      end
      ST_STRAY_LOW: put_quad(16'hdc00 + 16'($urandom_range(0, 1023)));
      ST_BAD_LEAD: begin
        if ($urandom_range(0, 1) != 0) put_src(8'($urandom_range(8'h80, 8'hc1)), 1'b0);
        else put_src(8'($urandom_range(8'hf5, 8'hff)), 1'b0);
      end
      ST_TRUNC_UTF8: begin
        put_lead(lead, len);
        repeat ($urandom_range(0, len - 2)) put_src(8'($urandom), 1'b0);
        put_src(8'($urandom), 1'b1);
      end
      ST_BAD_CONT: begin
        put_lead(lead, len);
        pos = $urandom_range(1, len - 1);
        for (int k = 1; k < len; k++) begin
          if (k == pos) begin
            do c = 8'($urandom); while (c[7:6] == 2'b10);
          end else begin
            c = 8'($urandom);
          end
          put_src(c, 1'b0);
        end
      end
      ST_OVERLONG: begin
        case ($urandom_range(0, 3))
          0: begin
            put_src(8'he0, 1'b0);
            put_src(8'($urandom_range(8'h80, 8'h9f)), 1'b0);
          end
          1: begin
            put_src(8'hed, 1'b0);
            put_src(8'($urandom_range(8'ha0, 8'hbf)), 1'b0);
          end
          2: begin
            put_src(8'hf0, 1'b0);
            put_src(8'($urandom_range(8'h80, 8'h8f)), 1'b0);
            put_src(8'($urandom_range(8'h80, 8'hbf)), 1'b0);
          end
          default: begin
            put_src(8'hf4, 1'b0);
            put_src(8'($urandom_range(8'h90, 8'hbf)), 1'b0);
            put_src(8'($urandom_range(8'h80, 8'hbf)), 1'b0);
          end
        endcase
        put_src(8'($urandom_range(8'h80, 8'hbf)), 1'b0);
      end
      default: ;
    endcase
  endtask

  // Driving and checking

  task automatic send_src(input logic [7:0] d, input logic e);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= d;
    end_of_source_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (dec_phase == DP_DONE) ignored_items++;
  endtask

  task automatic feed(input logic [7:0] d, input logic e, input logic predicted);
    send_src(d, e);
    decode_source_byte(d, e);
    if (predicted) begin
      for (int k = 0; k < step_n; k++) expect_item(step_res[k]);
    end
  endtask

  task automatic check_result();
    out_item_t got;
    out_item_t want;
    got = '{data: out_byte_o, valid: byte_valid_o, status: status_e'(status_o), last: last_o};
    results_seen++;
    if (got.valid === 1'b1) data_seen++;
    else last_status = got.status;
    if (decoded_q.size() == 0) begin
      mism_cnt++;
      if (mism_cnt <= MAX_SHOWN)
        $display("Unexpected result: byte %02h valid %0b status %0d last %0b",
                 got.data, got.valid, status_o, got.last);
    end else begin
      want = decoded_q.pop_front();
      if (got.data !== want.data || got.valid !== want.valid ||
          got.status !== want.status || got.last !== want.last) begin
        mism_cnt++;
        if (mism_cnt <= MAX_SHOWN)
          $display("Result %0d (byte/valid/status/last): expected %02h/%0b/%s/%0b, %s",
                   results_seen, want.data, want.valid, want.status.name(), want.last,
                   $sformatf("got %02h/%0b/%0d/%0b", got.data, got.valid, status_o,
                             got.last));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && out_ready_i) begin
      check_result();
      if (!calm) begin
        stall_draw = $urandom_range(0, MAX_WAIT);
        if (stall_draw != 0) begin
          out_ready_i <= 1'b0;
          stall_left  <= stall_draw - 1;
        end
      end
    end else if (!out_ready_i) begin
      if (stall_left == 0) out_ready_i <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    in_byte_i       <= 8'h00;
    end_of_source_i <= 1'b0;
    dec_phase       = DP_QUOTE;
    quad_acc        = '0;
    quad_cnt        = '0;
    quad_bad        = 1'b0;
    hi_bits         = '0;
    seq_buf         = '{default: 8'h00};
    seq_len         = '0;
    seq_cnt         = '0;
    seq_cont_bad    = 1'b0;
    seq_range_bad   = 1'b0;
    items_sent      = 0;
    ignored_items   = 0;
    results_seen    = 0;
    data_seen       = 0;
    mism_cnt        = 0;
    calm            = 1'b0;
    last_status     = ST_OK;

    // One string per reset: valid tokens keep it open, one chosen ending closes it.
    while (src_q.size() < RAND_ITEMS) put_token();
    do ending = status_e'($urandom_range(1, 15)); while (ending == ST_NO_QUOTE);
    put_ending(ending);
    repeat (8) put_src(8'($urandom), 1'($urandom_range(0, 1)));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      feed(dir_tab[i].data, 1'b0, !dir_tab[i].has_want);
      if (dir_tab[i].has_want && dir_tab[i].n != 3'd0)
        expect_item('{data: dir_tab[i].want, valid: 1'b1, status: ST_OK, last: 1'b1});
    end

    foreach (src_q[i]) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == RAND_ITEMS / 2) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (decoded_q.size() != 0);
      end
      feed(src_q[i].data, src_q[i].eos, 1'b1);
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (decoded_q.size() != 0);
    repeat (16) @(posedge clk_i);

    $display("Fed %0d source items, %0d of them after the string had ended.",
             items_sent, ignored_items);
    $display("Checked %0d results (%0d data bytes); ending %s, last status seen %s.",
             results_seen, data_seen, ending.name(), last_status.name());
    if (mism_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d results did not match.", mism_cnt);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/jsu_pkg.sv
hdl/jsu_decode.sv
hdl/jsu_out_queue.sv
hdl/json_string_unescape_utf8.sv
hdl/jsu_checker.sv
tb/sv/json_string_unescape_utf8_tb.sv
